[sv/connection_header_field_parser_macros.svh]
// ----------------------------------------------------------------------------
// Connection header field parser - assertion macros
// Shared concurrent assertion forms for the header parser checks.
// ----------------------------------------------------------------------------
`ifndef CONNECTION_HEADER_FIELD_PARSER_MACROS_SVH
`define CONNECTION_HEADER_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("header parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("header parser check failed");

`endif

[sv/chfp_pkg.sv]
// ----------------------------------------------------------------------------
// Connection header field parser - package
// Shared types, key table and constants for the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package chfp_pkg;

	// Default width of the header byte position counters.
	localparam int POSITION_BITS_DEFAULT = 16;

	// Number of recognized keys and the padded key table depth.
	localparam int NUM_KEYS  = 5;
	localparam int KEY_DEPTH = 16;

	// Field identifiers.
	localparam logic [2:0] FIELD_CALLERID    = 3'd0;
	localparam logic [2:0] FIELD_MD5SUM      = 3'd1;
	localparam logic [2:0] FIELD_TCP_NODELAY = 3'd2;
	localparam logic [2:0] FIELD_TOPIC       = 3'd3;
	localparam logic [2:0] FIELD_TYPE        = 3'd4;
	localparam logic [2:0] FIELD_END         = 3'd5;

	// Result queue depth; an item may produce two results.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Key text, including the trailing '=', padded with zeros.
	localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_DEPTH] = '{
		'{"c", "a", "l", "l", "e", "r", "i", "d", "=", 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "d", "5", "s", "u", "m", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "c", "p", "_", "n", "o", "d", "e", "l", "a", "y", "=",
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "o", "p", "i", "c", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "y", "p", "e", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00}
	};

	// Key lengths in bytes, including the '='.
	localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd9, 4'd7, 4'd12, 4'd6, 4'd5};

	// One result item.
	typedef struct packed {
		logic [2:0]  field_id;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic        truncated;
		logic        last_result;
	} result_t;

	// Results produced by one processed byte, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

[sv/chfp_parser.sv]
// ----------------------------------------------------------------------------
// Connection header field parser - parse core
// Tracks length words and entry bytes and matches entry keys, one byte a cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module chfp_parser #(
	parameter int POSITION_BITS = chfp_pkg::POSITION_BITS_DEFAULT
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  fire,
	input  wire  [7:0]           data_byte,
	input  wire                  is_last,
	output chfp_pkg::push_t      push
);

	localparam int OFF_W = (POSITION_BITS + 1 > 17) ? POSITION_BITS + 1 : 17;

	// Parser state.
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [POSITION_BITS-1:0] start_q, start_n;
	logic                     in_payload_q, in_payload_n;
	logic [1:0]               lbi_q, lbi_n;
	logic [31:0]              entry_len_q, entry_len_n;
	logic [31:0]              rem_q, rem_n;
	logic [4:0]               cand_q, cand_n;
	logic [3:0]               kci_q, kci_n;

	// Match and result terms.
	logic                     match;
	logic [2:0]               match_id;
	logic [3:0]               match_len;
	logic                     trunc;
	logic [OFF_W-1:0]         off_wide;
	logic [31:0]              len_wide;
	logic [15:0]              off_sat;
	logic [15:0]              len_sat;
	chfp_pkg::result_t        field_res;
	chfp_pkg::result_t        end_res;

	// Next-state logic for one byte.
	always_comb begin
		logic hit;
		logic fin;
		pos_n        = pos_q;
		start_n      = start_q;
		in_payload_n = in_payload_q;
		lbi_n        = lbi_q;
		entry_len_n  = entry_len_q;
		rem_n        = rem_q;
		cand_n       = cand_q;
		kci_n        = kci_q;
		match        = 1'b0;
		match_id     = chfp_pkg::FIELD_CALLERID;
		match_len    = 4'd0;
		hit          = 1'b0;
		fin          = 1'b0;

		if (!in_payload_q) begin
			// Little-endian length word.
			entry_len_n = entry_len_q | ({24'd0, data_byte} << {lbi_q, 3'b000});
			if (lbi_q == 2'd3) begin
				lbi_n = 2'd0;
				if (entry_len_n != 32'd0) begin
					in_payload_n = 1'b1;
					rem_n        = entry_len_n;
					cand_n       = '1;
					kci_n        = 4'd0;
				end
			end else begin
				lbi_n = lbi_q + 2'd1;
			end
		end else begin
			if (kci_q == 4'd0) begin
				start_n = pos_q;
			end
			// Compare against every key still in the running.
			for (int k = 0; k < chfp_pkg::NUM_KEYS; k++) begin
				hit = cand_q[k] && (kci_q < chfp_pkg::KEY_LEN[k]) &&
				      (data_byte == chfp_pkg::KEY_TEXT[k][kci_q]);
				fin = hit && (kci_q == chfp_pkg::KEY_LEN[k] - 4'd1);
				if (fin) begin
					match     = 1'b1;
					match_id  = 3'(k);
					match_len = chfp_pkg::KEY_LEN[k];
				end
				cand_n[k] = hit && !fin;
			end
			if (kci_q != 4'hF) begin
				kci_n = kci_q + 4'd1;
			end
			rem_n = rem_q - 32'd1;
			// Last byte of the entry: expect a new length word.
			if (rem_q == 32'd1) begin
				in_payload_n = 1'b0;
				lbi_n        = 2'd0;
				entry_len_n  = 32'd0;
				cand_n       = '1;
				kci_n        = 4'd0;
			end
		end

		if (pos_q != {POSITION_BITS{1'b1}}) begin
			pos_n = pos_q + {{(POSITION_BITS-1){1'b0}}, 1'b1};
		end

		trunc = in_payload_n || (lbi_n != 2'd0);

		// End of header returns everything to the reset state.
		if (is_last) begin
			pos_n        = '0;
			start_n      = '0;
			in_payload_n = 1'b0;
			lbi_n        = 2'd0;
			entry_len_n  = 32'd0;
			rem_n        = 32'd0;
			cand_n       = '1;
			kci_n        = 4'd0;
		end
	end

	// Value offset and length, saturated to 16 bits.
	always_comb begin
		logic [POSITION_BITS-1:0] eff_start;
		eff_start = (kci_q == 4'd0) ? pos_q : start_q;
		off_wide  = OFF_W'(eff_start) + OFF_W'(match_len);
		len_wide  = entry_len_q - 32'(match_len);
		off_sat   = (off_wide > OFF_W'(17'h0FFFF)) ? 16'hFFFF : off_wide[15:0];
		len_sat   = (len_wide[31:16] != 16'd0) ? 16'hFFFF : len_wide[15:0];
	end

	// Result items for this byte, field result first.
	always_comb begin
		field_res.field_id     = match_id;
		field_res.value_offset = off_sat;
		field_res.value_length = len_sat;
		field_res.truncated    = 1'b0;
		field_res.last_result  = 1'b0;
		end_res.field_id       = chfp_pkg::FIELD_END;
		end_res.value_offset   = 16'd0;
		end_res.value_length   = 16'd0;
		end_res.truncated      = trunc;
		end_res.last_result    = 1'b1;

		push.r0 = match ? field_res : end_res;
		push.r1 = end_res;
		if (!fire) begin
			push.count = 2'd0;
		end else if (match) begin
			push.count = is_last ? 2'd2 : 2'd1;
		end else begin
			push.count = is_last ? 2'd1 : 2'd0;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			start_q      <= '0;
			in_payload_q <= 1'b0;
			lbi_q        <= 2'd0;
			entry_len_q  <= 32'd0;
			rem_q        <= 32'd0;
			cand_q       <= '1;
			kci_q        <= 4'd0;
		end else if (fire) begin
			pos_q        <= pos_n;
			start_q      <= start_n;
			in_payload_q <= in_payload_n;
			lbi_q        <= lbi_n;
			entry_len_q  <= entry_len_n;
			rem_q        <= rem_n;
			cand_q       <= cand_n;
			kci_q        <= kci_n;
		end
	end

endmodule

`default_nettype wire

[sv/chfp_out_fifo.sv]
// ----------------------------------------------------------------------------
// Connection header field parser - result queue
// Small queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module chfp_out_fifo (
	input  wire                               clk,
	input  wire                               arst_n,
	input  chfp_pkg::push_t                   push,
	input  wire                               pop,
	output chfp_pkg::result_t                 head,
	output logic                              not_empty,
	output logic [chfp_pkg::FIFO_AW:0]        level
);

	chfp_pkg::result_t                 mem [chfp_pkg::FIFO_DEPTH];
	logic [chfp_pkg::FIFO_AW-1:0]      wr_q;
	logic [chfp_pkg::FIFO_AW-1:0]      rd_q;
	logic [chfp_pkg::FIFO_AW:0]        count_q;
	logic [chfp_pkg::FIFO_AW-1:0]      wr_next;

	assign wr_next   = wr_q + {{(chfp_pkg::FIFO_AW-1){1'b0}}, 1'b1};
	assign head      = mem[rd_q];
	assign not_empty = (count_q != '0);
	assign level     = count_q;

	// Storage; the second result goes one slot after the first.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wr_next] <= push.r1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + (chfp_pkg::FIFO_AW)'(push.count);
			if (pop) begin
				rd_q <= rd_q + {{(chfp_pkg::FIFO_AW-1){1'b0}}, 1'b1};
			end
			count_q <= count_q + (chfp_pkg::FIFO_AW + 1)'(push.count)
			           - (chfp_pkg::FIFO_AW + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

[sv/connection_header_field_parser.sv]
// Data path: a header byte accepted into the input register is parsed from that register;
// its results are written into the result queue and presented from the queue head.
// Throughput: one byte per cycle while the queue has room for two more results; a byte
// that yields two results is absorbed by the queue.
// Reset: arst_n clears the parser to the start of a header and empties the queue.
// ----------------------------------------------------------------------------
// Connection header field parser - top level
// Streams header bytes in, streams matched key fields and end markers out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "connection_header_field_parser_macros.svh"

module connection_header_field_parser #(
	parameter int POSITION_BITS = chfp_pkg::POSITION_BITS_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire         s_axis_tlast,   // is_last
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [15:0] value_offset, [31:16] value_length,
	                                    // [32] truncated, [39:33] zero
	output logic [2:0]  m_axis_tuser,   // [2:0] field_id
	output logic        m_axis_tlast    // last_result
);

	logic                         valid_s1;
	logic [7:0]                   data_s1;
	logic                         last_s1;
	logic                         proc;
	logic                         pop;
	logic [chfp_pkg::FIFO_AW:0]   level;
	logic                         not_empty;
	chfp_pkg::push_t              push;
	chfp_pkg::result_t            head;

	// A byte is parsed only when the queue can take two more results.
	assign proc          = valid_s1 &&
	                       (level <= (chfp_pkg::FIFO_AW + 1)'(chfp_pkg::FIFO_DEPTH - 2));
	assign s_axis_tready = !valid_s1 || proc;
	assign pop           = m_axis_tvalid && m_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	chfp_parser #(
		.POSITION_BITS(POSITION_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (proc),
		.data_byte (data_s1),
		.is_last   (last_s1),
		.push      (push)
	);

	chfp_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.level     (level)
	);

	// Output packing.
	assign m_axis_tvalid = not_empty;
	assign m_axis_tdata  = {7'd0, head.truncated, head.value_length, head.value_offset};
	assign m_axis_tuser  = head.field_id;
	assign m_axis_tlast  = head.last_result;

	// A stalled byte stays in the input register unchanged.
	`CHFP_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !proc,
		valid_s1 && $stable(data_s1) && $stable(last_s1))
	// The queue never receives more results than it has room for.
	`CHFP_ASSERT_SAME(a_no_overflow, clk, arst_n, push.count != 2'd0,
		proc && ((chfp_pkg::FIFO_AW + 1)'(push.count) + level <=
		(chfp_pkg::FIFO_AW + 1)'(chfp_pkg::FIFO_DEPTH)))
	// An end-of-header result always carries the end field id and no value.
	`CHFP_ASSERT_SAME(a_end_item, clk, arst_n, m_axis_tvalid && m_axis_tlast,
		(m_axis_tuser == chfp_pkg::FIELD_END) && (m_axis_tdata[31:0] == 32'd0))
	// Two results from one byte only happen on the final byte.
	`CHFP_ASSERT_SAME(a_two_only_last, clk, arst_n, push.count == 2'd2,
		last_s1 && push.r1.last_result)

endmodule

`default_nettype wire
